[design/rles_pkg.sv]
// Shared types, constants and the gradient color table of the RGB LED effect sequencer.
`timescale 1ns / 1ps

package rles_pkg;

    localparam int CHANNELS    = 8;
    localparam int PERIOD_BITS = 16;

    localparam int REG_SLOTS  = 8;
    localparam int REG_W      = 42;
    localparam int IDX_W      = 4;
    localparam int CH_W       = 3;
    localparam int COLOR_W    = 24;
    localparam int COLOR_LSB  = 2;
    localparam int PERIOD_LSB = 26;
    localparam int STEP_W     = 4;
    localparam int TABLE_LEN  = 11;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_STABLE   = 2'd1,
        MODE_BLINK    = 2'd2,
        MODE_GRADIENT = 2'd3
    } mode_t;

    // Sequencing controls shared by every cell
    typedef struct packed {
        logic step;
        logic launch;
    } cell_ctrl_t;

    // Register write aimed at one cell
    typedef struct packed {
        logic             we;
        logic [REG_W-1:0] data;
    } cfg_wr_t;

    // Result word passed down the cell row
    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [COLOR_W-1:0] color;
        logic               last;
    } res_t;

    function automatic logic [COLOR_W-1:0] grad_color(input logic [STEP_W-1:0] idx);
        logic [COLOR_W-1:0] c;
        unique case (idx)
            4'd0:    c = 24'hE5004B;
            4'd1:    c = 24'hCE1350;
            4'd2:    c = 24'hB72655;
            4'd3:    c = 24'hA0395A;
            4'd4:    c = 24'h894C60;
            4'd5:    c = 24'h725F65;
            4'd6:    c = 24'h5B726A;
            4'd7:    c = 24'h448570;
            4'd8:    c = 24'h2D9875;
            4'd9:    c = 24'h16AB7A;
            4'd10:   c = 24'h00BF80;
            default: c = 24'hE5004B;
        endcase
        return c;
    endfunction

endpackage

[design/rgb_led_effect_sequencer_top.sv]
// Top level of the RGB LED effect sequencer: row of channel cells and output register.
// An accepted refresh registers the token in cell 0; its word then loads the output register.
// Throughput: one word per cycle while out_ready is high, CHANNELS words per refresh; the
// refresh token walks the cell row one cell per cycle unless the output stalls.
// Output stalls hold the token in place; the next refresh is taken once it leaves the row.
// Reset (rst_n, async low) sets all channels off with cleared counters, dark, table step 0.
`timescale 1ns / 1ps

module rgb_led_effect_sequencer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          advance,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rles_pkg::CH_W-1:0]     channel,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rles_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rles_pkg::REG_W-1:0]    cfg_data
);

    localparam int N = rles_pkg::CHANNELS;

    logic [N-1:0]          tok_w;
    logic [N-1:0]          adv_w;
    rles_pkg::res_t        res_w [N];
    rles_pkg::cell_ctrl_t  ctrl;
    logic                  busy;
    logic                  in_accept;
    logic                  cfg_accept;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    rles_pkg::res_t        out_word_reg;

    assign busy       = |tok_w;
    assign in_ready   = !busy;
    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Step the token when the output register can take a word
    assign ctrl.launch = in_accept;
    assign ctrl.step   = busy && (!out_valid_reg || out_ready);

    // Row of channel cells
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        rles_pkg::cfg_wr_t cfg_w;
        logic              tok_prev;
        logic              adv_prev;
        rles_pkg::res_t    res_prev;

        assign cfg_w.we   = cfg_accept &&
                            (cfg_index == rles_pkg::IDX_W'(i));
        assign cfg_w.data = cfg_data;

        if (i == 0)
        begin : g_head
            assign tok_prev = in_accept;
            assign adv_prev = advance;
            assign res_prev = '0;
        end
        else
        begin : g_body
            assign tok_prev = tok_w[i-1];
            assign adv_prev = adv_w[i-1];
            assign res_prev = res_w[i-1];
        end

        rles_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (rles_pkg::CH_W'(i)),
            .ctrl    (ctrl),
            .cfg     (cfg_w),
            .tok_in  (tok_prev),
            .adv_in  (adv_prev),
            .tok_out (tok_w[i]),
            .adv_out (adv_w[i]),
            .res_in  (res_prev),
            .res_out (res_w[i])
        );
    end

    // Output register: load a word on each step, drop it when taken
    always_comb
    begin
        if (ctrl.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            out_word_reg <= res_w[N-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign channel   = out_word_reg.channel;
    assign red       = out_word_reg.color[23:16];
    assign green     = out_word_reg.color[15:8];
    assign blue      = out_word_reg.color[7:0];
    assign last      = out_word_reg.last;

endmodule

[design/rles_cell.sv]
// One LED channel cell: setup register, tick counter, blink and gradient state.
`timescale 1ns / 1ps

module rles_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [rles_pkg::CH_W-1:0] cell_id,
    input  rles_pkg::cell_ctrl_t  ctrl,
    input  rles_pkg::cfg_wr_t     cfg,
    input  logic                  tok_in,
    input  logic                  adv_in,
    output logic                  tok_out,
    output logic                  adv_out,
    input  rles_pkg::res_t        res_in,
    output rles_pkg::res_t        res_out
);

    logic [rles_pkg::REG_W-1:0]       setup_reg;
    logic [rles_pkg::PERIOD_BITS-1:0] cnt_reg;
    logic                             lit_reg;
    logic [rles_pkg::STEP_W-1:0]      step_reg;
    logic                             tok_reg;
    logic                             adv_reg;

    rles_pkg::mode_t                  mode;
    logic [rles_pkg::COLOR_W-1:0]     color;
    logic [rles_pkg::PERIOD_BITS-1:0] period;
    logic [rles_pkg::PERIOD_BITS-1:0] cnt_inc;
    logic                             counting;
    logic                             wrap;
    logic                             act;
    logic [rles_pkg::PERIOD_BITS-1:0] cnt_next;
    logic                             lit_next;
    logic [rles_pkg::STEP_W-1:0]      step_next;
    logic [rles_pkg::COLOR_W-1:0]     shown;
    rles_pkg::res_t                   own;

    // Decode the setup register
    assign mode   = rles_pkg::mode_t'(setup_reg[1:0]);
    assign color  = setup_reg[rles_pkg::COLOR_LSB +: rles_pkg::COLOR_W];
    assign period = setup_reg[rles_pkg::PERIOD_LSB +: rles_pkg::PERIOD_BITS];

    // Advance the tick count; act when it reaches the period or wraps
    assign cnt_inc  = cnt_reg + 1'b1;
    assign counting = adv_reg && (mode == rles_pkg::MODE_BLINK ||
                                  mode == rles_pkg::MODE_GRADIENT);
    assign wrap     = (cnt_inc >= period) || (cnt_inc == '0);
    assign act      = tok_reg && ctrl.step;

    always_comb
    begin
        cnt_next  = cnt_reg;
        lit_next  = lit_reg;
        step_next = step_reg;
        if (counting)
        begin
            cnt_next = wrap ? '0 : cnt_inc;
            if (wrap && mode == rles_pkg::MODE_BLINK)
            begin
                lit_next = ~lit_reg;
            end
            if (wrap && mode == rles_pkg::MODE_GRADIENT)
            begin
                step_next = (step_reg >= rles_pkg::STEP_W'(rles_pkg::TABLE_LEN - 1)) ?
                            '0 : step_reg + 1'b1;
            end
        end
    end

    // Pick the shown color from the updated state
    always_comb
    begin
        unique case (mode)
            rles_pkg::MODE_OFF:      shown = '0;
            rles_pkg::MODE_STABLE:   shown = color;
            rles_pkg::MODE_BLINK:    shown = lit_next ? color : '0;
            rles_pkg::MODE_GRADIENT: shown = rles_pkg::grad_color(step_next);
        endcase
    end

    // Channel state: register writes clear the effect state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg <= '0;
            cnt_reg   <= '0;
            lit_reg   <= 1'b0;
            step_reg  <= '0;
        end
        else if (cfg.we)
        begin
            setup_reg <= cfg.data;
            cnt_reg   <= '0;
            lit_reg   <= 1'b0;
            step_reg  <= '0;
        end
        else if (act)
        begin
            cnt_reg  <= cnt_next;
            lit_reg  <= lit_next;
            step_reg <= step_next;
        end
    end

    // Hand the refresh token on to the neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else if (ctrl.step || ctrl.launch)
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step || ctrl.launch)
        begin
            adv_reg <= adv_in;
        end
    end

    assign tok_out = tok_reg;
    assign adv_out = adv_reg;

    // Drive this channel's word onto the result chain while holding the token
    assign own.channel = cell_id;
    assign own.color   = shown;
    assign own.last    = (cell_id == rles_pkg::CH_W'(rles_pkg::CHANNELS - 1));
    assign res_out     = tok_reg ? own : res_in;

endmodule

[design/rles_checker.sv]
// Port-level checks of the RGB LED effect sequencer and their binding to the top level.
`timescale 1ns / 1ps

module rles_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rles_pkg::CH_W-1:0]  channel,
    input logic [7:0]                 red,
    input logic [7:0]                 green,
    input logic [7:0]                 blue,
    input logic                       last
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(red) &&
                                    $stable(green) && $stable(blue) && $stable(last))
        else $error("stalled output word changed");

    // A refresh in progress blocks the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a refresh started");

    // Flag only the final channel as last
    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (channel == rles_pkg::CH_W'(rles_pkg::CHANNELS - 1))))
        else $error("last flag does not match channel");

    // A mid-refresh word on the output keeps the input closed
    a_mid_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input opened before the refresh finished");

endmodule

bind rgb_led_effect_sequencer_top rles_checker u_rles_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .channel   (channel),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .last      (last)
);

[tb/rgb_led_effect_sequencer_top_tb.sv]
// Self-checking testbench for the RGB LED effect sequencer: refresh driver, word monitor, predictor.
`timescale 1ns / 1ps

module rgb_led_effect_sequencer_top_tb;

    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 60;
    localparam int IDLE_PCT      = 18;

    // Gradient ramp, entry 0 in the low bits
    localparam logic [rles_pkg::TABLE_LEN*rles_pkg::COLOR_W-1:0] GRAD_RAMP = {
        24'h00BF80, 24'h16AB7A, 24'h2D9875, 24'h448570, 24'h5B726A, 24'h725F65,
        24'h894C60, 24'hA0395A, 24'hB72655, 24'hCE1350, 24'hE5004B
    };

    typedef struct {
        logic [rles_pkg::CH_W-1:0] channel;
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
        logic                      last;
    } led_word_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic                         advance   = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [rles_pkg::CH_W-1:0]    channel;
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic [7:0]                   blue;
    logic                         last;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [rles_pkg::IDX_W-1:0]   cfg_index = '0;
    logic [rles_pkg::REG_W-1:0]   cfg_data  = '0;

    // Predictor state
    logic [rles_pkg::REG_W-1:0]       setup_mirror [rles_pkg::REG_SLOTS];
    logic [rles_pkg::PERIOD_BITS-1:0] tick_cnt     [rles_pkg::REG_SLOTS];
    logic                             lit          [rles_pkg::REG_SLOTS];
    logic [rles_pkg::STEP_W-1:0]      grad_step    [rles_pkg::REG_SLOTS];

    logic      refresh_q [$];
    led_word_t duty_q [$];

    logic idle_on   = 1'b0;
    int   hold_reqs = 0;
    int   hold_done = 0;
    int   hold_left = 0;
    int   stall_cycles = 0;

    int errors          = 0;
    int refreshes_sent  = 0;
    int words_checked   = 0;
    int setups_written  = 0;
    int setups_ignored  = 0;

    rgb_led_effect_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .channel   (channel),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic logic [rles_pkg::REG_W-1:0] make_setup(
        input rles_pkg::mode_t                  m,
        input logic [rles_pkg::COLOR_W-1:0]     col,
        input logic [rles_pkg::PERIOD_BITS-1:0] per);
        return {per, col, m};
    endfunction

    // Mirror a setup write: store it and clear the channel's effect state; unused indexes are ignored
    function automatic void apply_setup(input logic [rles_pkg::IDX_W-1:0] idx,
                                        input logic [rles_pkg::REG_W-1:0] data);
        logic [rles_pkg::CH_W-1:0] slot;
        slot = idx[rles_pkg::CH_W-1:0];
        if (idx >= rles_pkg::REG_SLOTS)
        begin
            setups_ignored++;
            return;
        end
        setup_mirror[slot] = data;
        tick_cnt[slot]     = '0;
        lit[slot]          = 1'b0;
        grad_step[slot]    = '0;
    endfunction

    // Count one tick on a blinking or gradient channel, act when the period is reached
    function automatic void tick_channel(input int c);
        rles_pkg::mode_t                  m;
        logic [rles_pkg::PERIOD_BITS-1:0] per;
        m   = rles_pkg::mode_t'(setup_mirror[c][1:0]);
        per = setup_mirror[c][rles_pkg::PERIOD_LSB +: rles_pkg::PERIOD_BITS];
        if (m != rles_pkg::MODE_BLINK && m != rles_pkg::MODE_GRADIENT)
            return;
        tick_cnt[c] = tick_cnt[c] + 1'b1;
        if (tick_cnt[c] >= per || tick_cnt[c] == '0)
        begin
            tick_cnt[c] = '0;
            if (m == rles_pkg::MODE_BLINK)
                lit[c] = ~lit[c];
            else if (grad_step[c] >= rles_pkg::TABLE_LEN - 1)
                grad_step[c] = '0;
            else
                grad_step[c] = grad_step[c] + 1'b1;
        end
    endfunction

    function automatic logic [rles_pkg::COLOR_W-1:0] shown_color(input int c);
        logic [rles_pkg::COLOR_W-1:0] col;
        col = setup_mirror[c][rles_pkg::COLOR_LSB +: rles_pkg::COLOR_W];
        case (rles_pkg::mode_t'(setup_mirror[c][1:0]))
            rles_pkg::MODE_STABLE:   return col;
            rles_pkg::MODE_BLINK:    return lit[c] ? col : '0;
            rles_pkg::MODE_GRADIENT: return (grad_step[c] < rles_pkg::TABLE_LEN) ?
                GRAD_RAMP[grad_step[c]*rles_pkg::COLOR_W +: rles_pkg::COLOR_W] :
                GRAD_RAMP[0 +: rles_pkg::COLOR_W];
            default:                 return '0;
        endcase
    endfunction

    // Work out the eight duty words one refresh produces
    function automatic void predict_refresh(input logic tick);
        led_word_t                    w;
        logic [rles_pkg::COLOR_W-1:0] col;
        for (int c = 0; c < rles_pkg::CHANNELS; c++)
        begin
            if (tick)
                tick_channel(c);
            col       = shown_color(c);
            w.channel = c[rles_pkg::CH_W-1:0];
            w.red     = col[23:16];
            w.green   = col[15:8];
            w.blue    = col[7:0];
            w.last    = (c == rles_pkg::CHANNELS - 1);
            duty_q.push_back(w);
        end
    endfunction

    function automatic logic [rles_pkg::REG_W-1:0] random_setup();
        logic [rles_pkg::PERIOD_BITS-1:0] per;
        int                               pick;
        pick = $urandom_range(99);
        if (pick < 60)
            per = rles_pkg::PERIOD_BITS'($urandom_range(4));
        else if (pick < 82)
            per = rles_pkg::PERIOD_BITS'($urandom_range(20, 5));
        else if (pick < 92)
            per = rles_pkg::PERIOD_BITS'(100);
        else
            per = rles_pkg::PERIOD_BITS'($urandom);
        return make_setup(rles_pkg::mode_t'($urandom_range(3)),
                          rles_pkg::COLOR_W'($urandom), per);
    endfunction

    // Refresh driver: take words from the pending queue, idle at random
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_refresh(advance);
                refreshes_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (refresh_q.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    advance  <= refresh_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output ready: long hold-offs on request, random stalls otherwise
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_done != hold_reqs)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= hold_done + 1;
        end
        else
            out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    // Monitor: check every accepted word against the oldest prediction
    always @(posedge clk)
    begin
        led_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (duty_q.size() == 0)
                report_mismatch($sformatf("word for channel %0d with nothing pending", channel));
            else
            begin
                want = duty_q.pop_front();
                if (channel !== want.channel)
                    report_mismatch($sformatf("channel got %0d want %0d", channel, want.channel));
                if (red !== want.red)
                    report_mismatch($sformatf("ch %0d red got %02h want %02h",
                                              want.channel, red, want.red));
                if (green !== want.green)
                    report_mismatch($sformatf("ch %0d green got %02h want %02h",
                                              want.channel, green, want.green));
                if (blue !== want.blue)
                    report_mismatch($sformatf("ch %0d blue got %02h want %02h",
                                              want.channel, blue, want.blue));
                if (last !== want.last)
                    report_mismatch($sformatf("ch %0d last got %0b want %0b",
                                              want.channel, last, want.last));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("rgb_led_effect_sequencer_top_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic write_setup(input logic [rles_pkg::IDX_W-1:0] idx,
                               input logic [rles_pkg::REG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_setup(idx, data);
        setups_written++;
        cfg_valid <= 1'b0;
    endtask

    // Hold until every pending word is sent and checked, then, if settle is set, let the row drain
    task automatic wait_drained(input bit settle);
        while (refresh_q.size() != 0 || in_valid || duty_q.size() != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            refresh_q.push_back($urandom_range(99) < 75);
    endtask

    initial
    begin
        for (int c = 0; c < rles_pkg::REG_SLOTS; c++)
            apply_setup(rles_pkg::IDX_W'(c), '0);
        setups_ignored = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // All channels off after reset: report and tick
        refresh_q.push_back(1'b0);
        refresh_q.push_back(1'b1);
        wait_drained(1'b1);

        // Directed settings: every mode, extreme colors and periods, out-of-range index
        write_setup(4'd0, make_setup(rles_pkg::MODE_STABLE,   24'hFFFFFF, 16'h0000));
        write_setup(4'd1, make_setup(rles_pkg::MODE_STABLE,   24'h000000, 16'hFFFF));
        write_setup(4'd2, make_setup(rles_pkg::MODE_BLINK,    24'hA5C3E1, 16'h0000));
        write_setup(4'd3, make_setup(rles_pkg::MODE_BLINK,    24'hFFFFFF, 16'h0002));
        write_setup(4'd4, make_setup(rles_pkg::MODE_GRADIENT, 24'hFFFFFF, 16'h0000));
        write_setup(4'd5, make_setup(rles_pkg::MODE_GRADIENT, 24'h123456, 16'h0003));
        write_setup(4'd6, make_setup(rles_pkg::MODE_OFF,      24'hFFFFFF, 16'hFFFF));
        write_setup(4'd7, make_setup(rles_pkg::MODE_BLINK,    24'h00FF00, 16'hFFFF));
        write_setup(4'd8,  {rles_pkg::REG_W{1'b1}});
        write_setup(4'd15, rles_pkg::REG_W'({$urandom, $urandom}));

        // Enough ticks to wrap the gradient ramp, with report-only refreshes mixed in
        refresh_q.push_back(1'b0);
        for (int i = 0; i < 14; i++)
        begin
            refresh_q.push_back(1'b1);
            if (i == 6)
                refresh_q.push_back(1'b0);
        end
        wait_drained(1'b1);

        for (int p = 0; p < 6; p++)
        begin
            for (int c = 0; c < rles_pkg::REG_SLOTS; c++)
                if (p == 0 || $urandom_range(1))
                    write_setup(rles_pkg::IDX_W'(c), random_setup());
            if ($urandom_range(1))
                write_setup(rles_pkg::IDX_W'($urandom_range(15, rles_pkg::REG_SLOTS)),
                            rles_pkg::REG_W'({$urandom, $urandom}));
            idle_on <= (p != 2);
            if (p == 1)
                hold_reqs <= hold_reqs + 1;
            if (p == 3)
            begin
                // Pause the sender until the block is fully drained
                queue_random(20);
                wait_drained(1'b0);
                queue_random(20);
            end
            else
                queue_random(40);
            wait_drained(1'b1);
        end

        $display("covered %0d refreshes, %0d LED words checked across all modes",
                 refreshes_sent, words_checked);
        $display("with %0d setup writes (%0d to unused indexes), random stalls and a long hold-off",
                 setups_written, setups_ignored);
        if (errors == 0)
            $display("rgb_led_effect_sequencer_top_tb: done, clean");
        else
            $display("rgb_led_effect_sequencer_top_tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
design/rles_pkg.sv
design/rles_cell.sv
design/rgb_led_effect_sequencer_top.sv
design/rles_checker.sv
tb/rgb_led_effect_sequencer_top_tb.sv
